// ===== rtl/deq_pkg.sv =====
package deq_pkg;

   localparam int DEPTH_DEFAULT      = 16;
   localparam int DATA_WIDTH_DEFAULT = 32;

   localparam int MODE_WIDTH   = 3;
   localparam int STATUS_WIDTH = 2;
   localparam int OCC_WIDTH    = 5;
   localparam int WORD_WIDTH   = 32;

   localparam logic [MODE_WIDTH-1:0] MODE_PUSH_FRONT = 3'd0;
   localparam logic [MODE_WIDTH-1:0] MODE_PUSH_BACK  = 3'd1;
   localparam logic [MODE_WIDTH-1:0] MODE_POP_FRONT  = 3'd2;
   localparam logic [MODE_WIDTH-1:0] MODE_POP_BACK   = 3'd3;
   localparam logic [MODE_WIDTH-1:0] MODE_QUERY      = 3'd4;

   localparam logic [STATUS_WIDTH-1:0] STATUS_DONE  = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_FULL  = 2'd2;

   // operation broadcast to every cell of the chain
   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_SHIFT_RIGHT,
      CELL_SHIFT_LEFT,
      CELL_PUSH_BACK,
      CELL_DROP_BACK
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
   } cell_ctl_type;

   typedef enum logic [1:0] {
      FSM_IDLE   = 2'b01,
      FSM_SETTLE = 2'b10
   } fsm_state_type;

endpackage

// ===== rtl/double_ended_queue.sv =====
// Bounded double-ended queue of signed words, held in a chain of cells with
// the front word always in the first cell.
// Request channel: req_mode picks push front, push back, pop front, pop back
// or query; req_value is the word to push. Every request transfer yields one
// response transfer with status, the popped word, the front and back words,
// an empty flag and the occupancy as they stand after the operation.
// Latency: the response is valid in the cycle after the request transfer.
// Each request is followed by a settle state in which new requests stall, while
// the chain registers the word second from the back, which a later pop at the
// back returns as the new back word.
// A push when full answers full and is dropped; a pop when empty answers
// empty. Neither changes the contents.
// While a response waits under rsp_stall the block holds it and stalls new
// requests; the chain keeps its contents.
// Reset empties the queue (cell occupancy bits cleared) and drops any
// pending response; cell data is left as is.
module double_ended_queue
   import deq_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEFAULT,
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [MODE_WIDTH-1:0]          req_mode,
   input  logic signed [WORD_WIDTH-1:0]   req_value,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [STATUS_WIDTH-1:0]        rsp_status,
   output logic signed [WORD_WIDTH-1:0]   rsp_removed_value,
   output logic signed [WORD_WIDTH-1:0]   rsp_front_value,
   output logic signed [WORD_WIDTH-1:0]   rsp_back_value,
   output logic                           rsp_is_empty,
   output logic [OCC_WIDTH-1:0]           rsp_occupancy
);

   localparam int CW = $clog2(DEPTH + 1);

   logic [DATA_WIDTH-1:0] cell_word [DEPTH];
   logic [DATA_WIDTH-1:0] cell_pen  [DEPTH];
   logic [DEPTH-1:0]      cell_occ;
   cell_ctl_type          cell_ctl;

   logic signed [DATA_WIDTH-1:0] push_word;
   logic [DATA_WIDTH-1:0]        pen_or;

   fsm_state_type                state_ff, state_in;
   logic [CW-1:0]                count_ff, count_in;
   logic signed [DATA_WIDTH-1:0] back_ff, back_in;
   logic signed [DATA_WIDTH-1:0] penult_ff;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [STATUS_WIDTH-1:0]      rsp_status_ff, status;
   logic signed [WORD_WIDTH-1:0] rsp_removed_ff, rsp_front_ff, rsp_back_ff;
   logic                         rsp_empty_ff;
   logic [OCC_WIDTH-1:0]         rsp_occ_ff;

   logic                         accept, full, empty;
   cell_op_type                  op;
   logic signed [DATA_WIDTH-1:0] removed, front_new;

   assign push_word = DATA_WIDTH'(req_value);

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_word, right_word;
      logic                  left_occ, right_occ, right2_occ;

      if (i == 0) begin : g_first
         assign left_word = push_word;
         assign left_occ  = 1'b1;
      end else begin : g_mid
         assign left_word = cell_word[i-1];
         assign left_occ  = cell_occ[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_word = '0;
         assign right_occ  = 1'b0;
      end else begin : g_right
         assign right_word = cell_word[i+1];
         assign right_occ  = cell_occ[i+1];
      end

      if (i >= DEPTH - 2) begin : g_last2
         assign right2_occ = 1'b0;
      end else begin : g_right2
         assign right2_occ = cell_occ[i+2];
      end

      deq_cell #(
         .DATA_WIDTH (DATA_WIDTH)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (cell_ctl),
         .push_word   (push_word),
         .left_word   (left_word),
         .left_occ    (left_occ),
         .right_word  (right_word),
         .right_occ   (right_occ),
         .right2_occ  (right2_occ),
         .word        (cell_word[i]),
         .occ         (cell_occ[i]),
         .penult_word (cell_pen[i])
      );
   end

   // at most one cell is second from the back
   always_comb begin
      pen_or = '0;
      for (int i = 0; i < DEPTH; i++) begin
         pen_or = pen_or | cell_pen[i];
      end
   end

   assign full      = (count_ff == CW'(DEPTH));
   assign empty     = (count_ff == '0);
   assign req_stall = (state_ff != FSM_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      status    = STATUS_DONE;
      op        = CELL_HOLD;
      count_in  = count_ff;
      removed   = '0;
      front_new = cell_word[0];
      back_in   = back_ff;
      case (req_mode)
         MODE_PUSH_FRONT: begin
            if (full) begin
               status = STATUS_FULL;
            end else begin
               op        = CELL_SHIFT_RIGHT;
               count_in  = count_ff + CW'(1);
               front_new = push_word;
               if (empty) begin
                  back_in = push_word;
               end
            end
         end
         MODE_PUSH_BACK: begin
            if (full) begin
               status = STATUS_FULL;
            end else begin
               op       = CELL_PUSH_BACK;
               count_in = count_ff + CW'(1);
               back_in  = push_word;
               if (empty) begin
                  front_new = push_word;
               end
            end
         end
         MODE_POP_FRONT: begin
            if (empty) begin
               status = STATUS_EMPTY;
            end else begin
               op        = CELL_SHIFT_LEFT;
               count_in  = count_ff - CW'(1);
               removed   = cell_word[0];
               front_new = cell_word[1];
            end
         end
         MODE_POP_BACK: begin
            if (empty) begin
               status = STATUS_EMPTY;
            end else begin
               op       = CELL_DROP_BACK;
               count_in = count_ff - CW'(1);
               removed  = back_ff;
               back_in  = penult_ff;
            end
         end
         MODE_QUERY: ;
         default: ;
      endcase
      if (count_in == '0) begin
         front_new = '0;
         back_in   = '0;
      end
   end

   assign cell_ctl.op = accept ? op : CELL_HOLD;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FSM_IDLE: begin
            if (accept) begin
               state_in = FSM_SETTLE;
            end
         end
         FSM_SETTLE: state_in = FSM_IDLE;
         default:    state_in = FSM_IDLE;
      endcase
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      penult_ff <= pen_or;
      if (accept) begin
         back_ff        <= back_in;
         rsp_status_ff  <= status;
         rsp_removed_ff <= WORD_WIDTH'(removed);
         rsp_front_ff   <= WORD_WIDTH'(front_new);
         rsp_back_ff    <= WORD_WIDTH'(back_in);
         rsp_empty_ff   <= (count_in == '0);
         rsp_occ_ff     <= OCC_WIDTH'(count_in);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_removed_value = rsp_removed_ff;
   assign rsp_front_value   = rsp_front_ff;
   assign rsp_back_value    = rsp_back_ff;
   assign rsp_is_empty      = rsp_empty_ff;
   assign rsp_occupancy     = rsp_occ_ff;

   a_empty_matches_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_empty_ff == (count_ff == '0)))
      else $error("empty flag disagrees with held count");

   a_chain_ends: assert property (@(posedge clock) disable iff (reset)
      (cell_occ[0] == (count_ff != '0)) && (cell_occ[DEPTH-1] == (count_ff == CW'(DEPTH))))
      else $error("cell occupancy out of step with held count");

   a_refused_keeps_count: assert property (@(posedge clock) disable iff (reset)
      accept |=> ((rsp_status_ff == STATUS_DONE) || (count_ff == $past(count_ff))))
      else $error("refused operation changed the held count");

   a_settle_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> req_stall)
      else $error("request taken before the chain settled");

endmodule

// ===== rtl/deq_cell.sv =====
module deq_cell
   import deq_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cell_ctl_type          ctl,
   input  logic [DATA_WIDTH-1:0] push_word,
   input  logic [DATA_WIDTH-1:0] left_word,
   input  logic                  left_occ,
   input  logic [DATA_WIDTH-1:0] right_word,
   input  logic                  right_occ,
   input  logic                  right2_occ,
   output logic [DATA_WIDTH-1:0] word,
   output logic                  occ,
   output logic [DATA_WIDTH-1:0] penult_word
);

   logic [DATA_WIDTH-1:0] word_ff, word_in;
   logic                  occ_ff, occ_in;

   always_comb begin
      word_in = word_ff;
      occ_in  = occ_ff;
      case (ctl.op)
         CELL_SHIFT_RIGHT: begin
            word_in = left_word;
            occ_in  = left_occ;
         end
         CELL_SHIFT_LEFT: begin
            word_in = right_word;
            occ_in  = right_occ;
         end
         CELL_PUSH_BACK: begin
            // first free cell takes the word
            if (!occ_ff && left_occ) begin
               word_in = push_word;
               occ_in  = 1'b1;
            end
         end
         CELL_DROP_BACK: begin
            if (occ_ff && !right_occ) begin
               occ_in = 1'b0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   assign word        = word_ff;
   assign occ         = occ_ff;
   // this cell is second from the back: feeds the one-hot select
   assign penult_word = word_ff & {DATA_WIDTH{occ_ff & right_occ & ~right2_occ}};

endmodule
